>>> rtl/hvfc_pkg.sv
// ----------------------------------------------------------------------------
// hvfc_pkg
// shared types, constants and helpers of the heightmap voxel face culler
// ----------------------------------------------------------------------------
package hvfc_pkg;

   localparam int MAX_SIDE_DEF   = 32;
   localparam int MAX_HEIGHT_DEF = 64;

   // compare width for sizes, heights and levels (covers values up to 511)
   localparam int CMP_W = 9;

   localparam logic [5:0]  SIZE_RESET   = 6'd32;
   localparam logic [15:0] ORIGIN_RESET = 16'd0;

   // configuration register indexes
   localparam logic [1:0] CSR_SIZE_X   = 2'd0;
   localparam logic [1:0] CSR_SIZE_Z   = 2'd1;
   localparam logic [1:0] CSR_ORIGIN_X = 2'd2;
   localparam logic [1:0] CSR_ORIGIN_Z = 2'd3;

   // request operations
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // face codes, also bit positions of the visibility mask
   localparam logic [2:0] FACE_POS_X = 3'd0;
   localparam logic [2:0] FACE_NEG_X = 3'd1;
   localparam logic [2:0] FACE_POS_Y = 3'd2;
   localparam logic [2:0] FACE_NEG_Y = 3'd3;
   localparam logic [2:0] FACE_POS_Z = 3'd4;
   localparam logic [2:0] FACE_NEG_Z = 3'd5;
   localparam int         NUM_FACES  = 6;

   localparam logic [2:0] LAYER_TOP   = 3'd6;
   localparam logic [5:0] LAYER_LIMIT = 6'd18;   // 3 * LAYER_TOP

   typedef struct packed {
      logic [5:0]  size_x;
      logic [5:0]  size_z;
      logic [15:0] origin_x;
      logic [15:0] origin_z;
   } cfg_type;

   // min(y / 3, 6); y / 3 as (y * 43) >> 7, exact for y below 64
   function automatic logic [2:0] layer_of(input logic [5:0] y);
      logic [11:0] prod;
      prod = 12'(y) * 12'd43;
      if (y >= LAYER_LIMIT) begin
         return LAYER_TOP;
      end
      return prod[9:7];
   endfunction

endpackage

>>> rtl/hvfc_height_ram.sv
// ----------------------------------------------------------------------------
// hvfc_height_ram
// column height store, one write port and one read port, registered read
// ----------------------------------------------------------------------------
module hvfc_height_ram #(
   parameter int DEPTH  = hvfc_pkg::MAX_SIDE_DEF * hvfc_pkg::MAX_SIDE_DEF,
   parameter int ADDR_W = $clog2(DEPTH),
   parameter int DATA_W = $clog2(hvfc_pkg::MAX_HEIGHT_DEF + 1)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/hvfc_face_seq.sv
// ----------------------------------------------------------------------------
// hvfc_face_seq
// sequencer: clears the store, applies writes, reads a voxel's column and
// its four neighbors, then hands out the visible faces one per transfer
// ----------------------------------------------------------------------------
module hvfc_face_seq #(
   parameter int MAX_SIDE   = hvfc_pkg::MAX_SIDE_DEF,
   parameter int MAX_HEIGHT = hvfc_pkg::MAX_HEIGHT_DEF,
   parameter int ADDR_W     = $clog2(MAX_SIDE * MAX_SIDE),
   parameter int H_W        = $clog2(MAX_HEIGHT + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  hvfc_pkg::cfg_type      cfg,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_operation,
   input  logic [4:0]             req_cell_x,
   input  logic [4:0]             req_cell_z,
   input  logic [5:0]             req_level_y,
   input  logic [6:0]             req_height_value,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic signed [16:0]     rsp_world_x,
   output logic [5:0]             rsp_level_out,
   output logic signed [16:0]     rsp_world_z,
   output logic [2:0]             rsp_face,
   output logic [2:0]             rsp_color_layer,
   output logic                   rsp_last,
   output logic                   ram_wr_en,
   output logic [ADDR_W-1:0]      ram_wr_addr,
   output logic [H_W-1:0]         ram_wr_data,
   output logic [ADDR_W-1:0]      ram_rd_addr,
   input  logic [H_W-1:0]         ram_rd_data
);

   localparam int W = hvfc_pkg::CMP_W;
   localparam int DEPTH = MAX_SIDE * MAX_SIDE;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
   localparam logic [W-1:0] SIDE_CAP = W'(MAX_SIDE);
   localparam logic [W-1:0] HEIGHT_CAP = W'(MAX_HEIGHT);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EMIT
   } state_type;

   state_type   state_ff;
   logic [ADDR_W-1:0] clr_ff;
   logic [2:0]  cnt_ff;
   logic [4:0]  x_ff;
   logic [4:0]  z_ff;
   logic [5:0]  y_ff;
   logic [H_W-1:0] h_ff;
   logic        inside_ff;
   logic [hvfc_pkg::NUM_FACES-1:0] vis_ff;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic signed [16:0] rsp_world_x_ff;
   logic [5:0]         rsp_level_out_ff;
   logic signed [16:0] rsp_world_z_ff;
   logic [2:0]         rsp_face_ff;
   logic [2:0]         rsp_color_layer_ff;
   logic               rsp_last_ff;

   logic [W-1:0] size_x_eff;
   logic [W-1:0] size_z_eff;
   logic         req_accept;
   logic         req_in_range;
   logic [W-1:0] hv_sat;
   logic [W-1:0] y_ext;
   logic [W-1:0] rd_ext;
   logic         y_below_rd;
   logic [hvfc_pkg::NUM_FACES-1:0] final_mask;
   logic [2:0]   pick;
   logic [hvfc_pkg::NUM_FACES-1:0] rest_mask;
   logic         out_free;
   logic [16:0]  world_x;
   logic [16:0]  world_z;

   // linear entry index x + z * MAX_SIDE, wraps harmlessly for outside neighbors
   function automatic logic [ADDR_W-1:0] addr_of(input logic [W-1:0] x,
                                                  input logic [W-1:0] z);
      logic [2*W-1:0] a;
      a = (2*W)'(z) * (2*W)'(MAX_SIDE) + (2*W)'(x);
      return a[ADDR_W-1:0];
   endfunction

   assign size_x_eff = (W'(cfg.size_x) > SIDE_CAP) ? SIDE_CAP : W'(cfg.size_x);
   assign size_z_eff = (W'(cfg.size_z) > SIDE_CAP) ? SIDE_CAP : W'(cfg.size_z);

   assign req_stall    = (state_ff != ST_IDLE);
   assign req_accept   = req_valid && !req_stall;
   assign req_in_range = (W'(req_cell_x) < size_x_eff) && (W'(req_cell_z) < size_z_eff);
   assign hv_sat = (W'(req_height_value) > HEIGHT_CAP) ? HEIGHT_CAP : W'(req_height_value);

   assign y_ext      = W'(y_ff);
   assign rd_ext     = W'(ram_rd_data);
   assign y_below_rd = (y_ext < rd_ext);

   // memory port control
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = addr_of(W'(req_cell_x), W'(req_cell_z));
      ram_wr_data = hv_sat[H_W-1:0];
      ram_rd_addr = addr_of(W'(req_cell_x), W'(req_cell_z));
      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = H_W'(1);
         end
         ST_IDLE: begin
            ram_wr_en = req_accept && (req_operation == hvfc_pkg::OP_WRITE) && req_in_range;
         end
         ST_READ: begin
            // neighbor reads in face order +X, -X, +Z, -Z
            unique case (cnt_ff)
               3'd1:    ram_rd_addr = addr_of(W'(x_ff) + W'(1), W'(z_ff));
               3'd2:    ram_rd_addr = addr_of(W'(x_ff) - W'(1), W'(z_ff));
               3'd3:    ram_rd_addr = addr_of(W'(x_ff), W'(z_ff) + W'(1));
               3'd4:    ram_rd_addr = addr_of(W'(x_ff), W'(z_ff) - W'(1));
               default: ram_rd_addr = addr_of(W'(x_ff), W'(z_ff));
            endcase
         end
         ST_EMIT: begin
            ram_wr_en = 1'b0;
         end
         default: begin
            ram_wr_en = 1'b0;
         end
      endcase
   end

   // mask once the last neighbor height arrives
   always_comb begin
      final_mask = vis_ff;
      final_mask[hvfc_pkg::FACE_NEG_Z] = !((z_ff != 5'd0) && y_below_rd);
      final_mask[hvfc_pkg::FACE_POS_Y] = !((y_ext + W'(1)) < W'(h_ff));
      final_mask[hvfc_pkg::FACE_NEG_Y] = (y_ff == 6'd0);
      if (!inside_ff) begin
         final_mask = '0;
      end
   end

   // lowest pending face goes out first
   always_comb begin
      pick = hvfc_pkg::FACE_POS_X;
      for (int i = hvfc_pkg::NUM_FACES - 1; i >= 0; i--) begin
         if (vis_ff[i]) begin
            pick = 3'(i);
         end
      end
      rest_mask = vis_ff;
      rest_mask[pick] = 1'b0;
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign world_x  = {cfg.origin_x[15], cfg.origin_x} + {12'd0, x_ff};
   assign world_z  = {cfg.origin_z[15], cfg.origin_z} + {12'd0, z_ff};

   // output register loads a face or holds a stalled one
   assign rsp_valid_in = ((state_ff == ST_EMIT) && out_free) || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         cnt_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + ADDR_W'(1);
               if (clr_ff == LAST_ADDR) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_accept && (req_operation == hvfc_pkg::OP_QUERY) && req_in_range) begin
                  x_ff     <= req_cell_x;
                  z_ff     <= req_cell_z;
                  y_ff     <= req_level_y;
                  cnt_ff   <= 3'd1;
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               cnt_ff <= cnt_ff + 3'd1;
               // data of the read issued in the cycle before
               unique case (cnt_ff)
                  3'd1: begin
                     h_ff      <= ram_rd_data;
                     inside_ff <= y_below_rd;
                  end
                  3'd2: begin
                     vis_ff[hvfc_pkg::FACE_POS_X] <=
                        !(((W'(x_ff) + W'(1)) < size_x_eff) && y_below_rd);
                  end
                  3'd3: begin
                     vis_ff[hvfc_pkg::FACE_NEG_X] <= !((x_ff != 5'd0) && y_below_rd);
                  end
                  3'd4: begin
                     vis_ff[hvfc_pkg::FACE_POS_Z] <=
                        !(((W'(z_ff) + W'(1)) < size_z_eff) && y_below_rd);
                  end
                  default: begin
                     vis_ff <= final_mask;
                     state_ff <= (final_mask == '0) ? ST_IDLE : ST_EMIT;
                  end
               endcase
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_world_x_ff     <= world_x;
                  rsp_world_z_ff     <= world_z;
                  rsp_level_out_ff   <= y_ff;
                  rsp_face_ff        <= pick;
                  rsp_color_layer_ff <= hvfc_pkg::layer_of(y_ff);
                  rsp_last_ff        <= (rest_mask == '0);
                  vis_ff             <= rest_mask;
                  if (rest_mask == '0) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_world_x     = rsp_world_x_ff;
   assign rsp_level_out   = rsp_level_out_ff;
   assign rsp_world_z     = rsp_world_z_ff;
   assign rsp_face        = rsp_face_ff;
   assign rsp_color_layer = rsp_color_layer_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

>>> rtl/heightmap_voxel_face_culler_core.sv
// ----------------------------------------------------------------------------
// heightmap_voxel_face_culler_core
// column height store with per-voxel visible face extraction
// ----------------------------------------------------------------------------
// usage:
//   req channel (valid/stall) carries write and query items. a write sets one
//   column height (saturated to MAX_HEIGHT) and gives no result; writes
//   outside size_x/size_z are dropped. a query reads its own column and the
//   four neighbors through the single read port of the height memory: five
//   reads, one per cycle. the mask is registered once the last neighbor
//   height arrives, then the first face goes to the rsp output register.
//   visible faces leave on the rsp channel one per cycle while the receiver
//   does not stall, in the order +X, -X, +Y, -Y, +Z, -Z, with rsp_last on
//   the final one. a query that shows no face gives no result. no new
//   request is taken until a query's last face is in the output register.
//   the csr port writes size and origin registers; write only while idle.
//   after reset a clearing pass sets every entry to 1, one entry per cycle,
//   MAX_SIDE*MAX_SIDE entries (1024 by default); req_stall is high meanwhile.
//   when the receiver stalls, the face in the output register holds and the
//   sequencer waits; a new request is taken while the last face still waits.
// ----------------------------------------------------------------------------
module heightmap_voxel_face_culler_core #(
   parameter int MAX_SIDE   = hvfc_pkg::MAX_SIDE_DEF,
   parameter int MAX_HEIGHT = hvfc_pkg::MAX_HEIGHT_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_operation,
   input  logic [4:0]         req_cell_x,
   input  logic [4:0]         req_cell_z,
   input  logic [5:0]         req_level_y,
   input  logic [6:0]         req_height_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [16:0] rsp_world_x,
   output logic [5:0]         rsp_level_out,
   output logic signed [16:0] rsp_world_z,
   output logic [2:0]         rsp_face,
   output logic [2:0]         rsp_color_layer,
   output logic               rsp_last,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_data
);

   localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int H_W    = $clog2(MAX_HEIGHT + 1);

   hvfc_pkg::cfg_type cfg_ff;

   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [H_W-1:0]    ram_wr_data;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [H_W-1:0]    ram_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.size_x   <= hvfc_pkg::SIZE_RESET;
         cfg_ff.size_z   <= hvfc_pkg::SIZE_RESET;
         cfg_ff.origin_x <= hvfc_pkg::ORIGIN_RESET;
         cfg_ff.origin_z <= hvfc_pkg::ORIGIN_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            hvfc_pkg::CSR_SIZE_X:   cfg_ff.size_x   <= csr_data[5:0];
            hvfc_pkg::CSR_SIZE_Z:   cfg_ff.size_z   <= csr_data[5:0];
            hvfc_pkg::CSR_ORIGIN_X: cfg_ff.origin_x <= csr_data;
            hvfc_pkg::CSR_ORIGIN_Z: cfg_ff.origin_z <= csr_data;
            default: begin
            end
         endcase
      end
   end

   hvfc_height_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W),
      .DATA_W (H_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   hvfc_face_seq #(
      .MAX_SIDE   (MAX_SIDE),
      .MAX_HEIGHT (MAX_HEIGHT),
      .ADDR_W     (ADDR_W),
      .H_W        (H_W)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_cell_x       (req_cell_x),
      .req_cell_z       (req_cell_z),
      .req_level_y      (req_level_y),
      .req_height_value (req_height_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_world_x      (rsp_world_x),
      .rsp_level_out    (rsp_level_out),
      .rsp_world_z      (rsp_world_z),
      .rsp_face         (rsp_face),
      .rsp_color_layer  (rsp_color_layer),
      .rsp_last         (rsp_last),
      .ram_wr_en        (ram_wr_en),
      .ram_wr_addr      (ram_wr_addr),
      .ram_wr_data      (ram_wr_data),
      .ram_rd_addr      (ram_rd_addr),
      .ram_rd_data      (ram_rd_data)
   );

endmodule

>>> tb/hvfc_face_checker.sv
// ----------------------------------------------------------------------------
// hvfc_face_checker
// watches the req, rsp and csr ports of the face culler, keeps its own column
// heights and registers, predicts the visible faces of every query and
// compares each rsp transfer with the oldest predicted face
// ----------------------------------------------------------------------------
module hvfc_face_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_operation,
   input  logic [4:0]  req_cell_x,
   input  logic [4:0]  req_cell_z,
   input  logic [5:0]  req_level_y,
   input  logic [6:0]  req_height_value,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [16:0] rsp_world_x,
   input  logic [5:0]  rsp_level_out,
   input  logic [16:0] rsp_world_z,
   input  logic [2:0]  rsp_face,
   input  logic [2:0]  rsp_color_layer,
   input  logic        rsp_last,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data,
   output int          fail_count,
   output int          pending
);

   localparam int SIDE       = hvfc_pkg::MAX_SIDE_DEF;
   localparam int LAYER_STEP = 3;

   typedef struct packed {
      logic [16:0] wx;
      logic [5:0]  lvl;
      logic [16:0] wz;
      logic [2:0]  face;
      logic [2:0]  layer;
      logic        last;
   } face_type;

   face_type    pending_faces[$];
   logic [6:0]  col_h [SIDE*SIDE];
   logic [5:0]  size_x_r = hvfc_pkg::SIZE_RESET;
   logic [5:0]  size_z_r = hvfc_pkg::SIZE_RESET;
   logic [15:0] org_x_r  = hvfc_pkg::ORIGIN_RESET;
   logic [15:0] org_z_r  = hvfc_pkg::ORIGIN_RESET;
   int          errors   = 0;

   function automatic int height_of(int x, int z);
      return int'(col_h[x + z * SIDE]);
   endfunction

   // applies one req transfer: a height write, or a query whose faces are queued
   task automatic cull_voxel(input logic op, input logic [4:0] cx, input logic [4:0] cz,
                             input logic [5:0] y, input logic [6:0] hv);
      int         sx, sz, x, z, yy, h, lastf;
      logic [5:0] vis;
      face_type   rec;
      sx = (size_x_r > SIDE) ? SIDE : int'(size_x_r);
      sz = (size_z_r > SIDE) ? SIDE : int'(size_z_r);
      x  = int'(cx);
      z  = int'(cz);
      yy = int'(y);
      if (x >= sx || z >= sz) return;
      if (op == hvfc_pkg::OP_WRITE) begin
         col_h[x + z * SIDE] = (hv > hvfc_pkg::MAX_HEIGHT_DEF) ?
                               7'(hvfc_pkg::MAX_HEIGHT_DEF) : hv;
         return;
      end
      h = height_of(x, z);
      if (yy >= h) return;
      // a side is hidden only by an in-chunk neighbor that is taller than y
      vis[hvfc_pkg::FACE_POS_X] = !(x + 1 < sx && yy < height_of(x + 1, z));
      vis[hvfc_pkg::FACE_NEG_X] = !(x >= 1 && yy < height_of(x - 1, z));
      vis[hvfc_pkg::FACE_POS_Y] = !(yy + 1 < h);
      vis[hvfc_pkg::FACE_NEG_Y] = (yy == 0);
      vis[hvfc_pkg::FACE_POS_Z] = !(z + 1 < sz && yy < height_of(x, z + 1));
      vis[hvfc_pkg::FACE_NEG_Z] = !(z >= 1 && yy < height_of(x, z - 1));
      lastf = -1;
      for (int f = hvfc_pkg::FACE_POS_X; f <= hvfc_pkg::FACE_NEG_Z; f++) begin
         if (vis[f]) lastf = f;
      end
      rec.wx    = {org_x_r[15], org_x_r} + 17'(x);
      rec.wz    = {org_z_r[15], org_z_r} + 17'(z);
      rec.lvl   = y;
      rec.layer = (yy / LAYER_STEP > int'(hvfc_pkg::LAYER_TOP)) ?
                  hvfc_pkg::LAYER_TOP : 3'(yy / LAYER_STEP);
      for (int f = hvfc_pkg::FACE_POS_X; f <= hvfc_pkg::FACE_NEG_Z; f++) begin
         if (vis[f]) begin
            rec.face = 3'(f);
            rec.last = (f == lastf);
            pending_faces.insert(pending_faces.size(), rec);
         end
      end
   endtask

   always @(posedge clock) begin
      face_type exp_f;
      if (reset) begin
         foreach (col_h[i]) col_h[i] = 7'd1;
         size_x_r = hvfc_pkg::SIZE_RESET;
         size_z_r = hvfc_pkg::SIZE_RESET;
         org_x_r  = hvfc_pkg::ORIGIN_RESET;
         org_z_r  = hvfc_pkg::ORIGIN_RESET;
         pending_faces.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_faces.size() == 0) begin
               errors++;
               if (errors <= 10) begin
                  $display("unexpected face: wx=%0d lvl=%0d wz=%0d face=%0d layer=%0d last=%0d",
                           $signed(rsp_world_x), rsp_level_out, $signed(rsp_world_z),
                           rsp_face, rsp_color_layer, rsp_last);
               end
            end else begin
               exp_f = pending_faces.pop_front();
               if (rsp_world_x !== exp_f.wx || rsp_level_out !== exp_f.lvl ||
                   rsp_world_z !== exp_f.wz || rsp_face !== exp_f.face ||
                   rsp_color_layer !== exp_f.layer || rsp_last !== exp_f.last) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("mismatch: exp wx=%0d lvl=%0d wz=%0d face=%0d layer=%0d last=%0d",
                              $signed(exp_f.wx), exp_f.lvl, $signed(exp_f.wz),
                              exp_f.face, exp_f.layer, exp_f.last);
                     $display("          got wx=%0d lvl=%0d wz=%0d face=%0d layer=%0d last=%0d",
                              $signed(rsp_world_x), rsp_level_out, $signed(rsp_world_z),
                              rsp_face, rsp_color_layer, rsp_last);
                  end
               end
            end
         end
         if (csr_write) begin
            case (csr_index)
               hvfc_pkg::CSR_SIZE_X:   size_x_r = csr_data[5:0];
               hvfc_pkg::CSR_SIZE_Z:   size_z_r = csr_data[5:0];
               hvfc_pkg::CSR_ORIGIN_X: org_x_r  = csr_data;
               hvfc_pkg::CSR_ORIGIN_Z: org_z_r  = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            cull_voxel(req_operation, req_cell_x, req_cell_z, req_level_y, req_height_value);
         end
      end
      fail_count <= errors;
      pending    <= pending_faces.size();
   end

endmodule

>>> tb/tb_heightmap_voxel_face_culler_core.sv
// ----------------------------------------------------------------------------
// tb_heightmap_voxel_face_culler_core
// drives directed and random height writes and voxel queries through several
// size and origin settings with random idling on both channels and one long
// receiver hold-off; the face checker predicts and compares every face
// ----------------------------------------------------------------------------
module tb_heightmap_voxel_face_culler_core;

   localparam int LIMIT       = 600000;
   localparam int SETTLE      = 16;
   localparam int HOLD_CYCLES = 400;

   logic               clock;
   logic               reset            = 1'b1;
   logic               req_valid        = 1'b0;
   logic               req_stall;
   logic               req_operation    = hvfc_pkg::OP_WRITE;
   logic [4:0]         req_cell_x       = '0;
   logic [4:0]         req_cell_z       = '0;
   logic [5:0]         req_level_y      = '0;
   logic [6:0]         req_height_value = '0;
   logic               rsp_valid;
   logic               rsp_stall        = 1'b0;
   logic signed [16:0] rsp_world_x;
   logic [5:0]         rsp_level_out;
   logic signed [16:0] rsp_world_z;
   logic [2:0]         rsp_face;
   logic [2:0]         rsp_color_layer;
   logic               rsp_last;
   logic               csr_write        = 1'b0;
   logic [1:0]         csr_index        = hvfc_pkg::CSR_SIZE_X;
   logic [15:0]        csr_data         = '0;

   int fail_count;
   int pending;
   int cycles    = 0;
   int rx_left   = 0;
   int rx_hold   = 0;
   bit tx_steady = 1'b0;
   bit rx_steady = 1'b0;
   bit hold_go   = 1'b0;
   bit hold_used = 1'b0;

   heightmap_voxel_face_culler_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_operation(req_operation),
      .req_cell_x(req_cell_x), .req_cell_z(req_cell_z), .req_level_y(req_level_y),
      .req_height_value(req_height_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_world_x(rsp_world_x),
      .rsp_level_out(rsp_level_out), .rsp_world_z(rsp_world_z), .rsp_face(rsp_face),
      .rsp_color_layer(rsp_color_layer), .rsp_last(rsp_last),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   hvfc_face_checker chk (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_operation(req_operation),
      .req_cell_x(req_cell_x), .req_cell_z(req_cell_z), .req_level_y(req_level_y),
      .req_height_value(req_height_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_world_x(rsp_world_x),
      .rsp_level_out(rsp_level_out), .rsp_world_z(rsp_world_z), .rsp_face(rsp_face),
      .rsp_color_layer(rsp_color_layer), .rsp_last(rsp_last),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      while (cycles < LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("TEST FAILED");
      $finish;
   end

   // mostly short gaps, a few long ones
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // coordinate mostly inside a small window so writes and queries meet
   function automatic int pick_coord(int size, int base);
      int r;
      r = $urandom_range(0, 9);
      if (size == 0 || r == 0) return $urandom_range(0, 31);
      if (r == 1) return $urandom_range(0, size - 1);
      return base + $urandom_range(0, ((size < 4) ? size : 4) - 1);
   endfunction

   // receiver: random stall runs, steady stretches and one long hold-off
   always @(posedge clock) begin
      if (hold_go && !hold_used) begin
         rx_hold   = HOLD_CYCLES;
         hold_used = 1'b1;
      end
      if (rx_hold > 0) begin
         rx_hold--;
         rsp_stall <= 1'b1;
      end else if (rx_left > 0) begin
         rx_left--;
         rsp_stall <= 1'b1;
      end else begin
         if ($urandom_range(0, 99) == 0) rx_steady = !rx_steady;
         rsp_stall <= 1'b0;
         if (!rx_steady) rx_left = idle_len();
      end
   end

   task automatic offer_req(input logic op, input logic [4:0] x, input logic [4:0] z,
                            input logic [5:0] y, input logic [6:0] hv);
      int gap;
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_cell_x       <= x;
      req_cell_z       <= z;
      req_level_y      <= y;
      req_height_value <= hv;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if ($urandom_range(0, 19) == 0) tx_steady = !tx_steady;
      gap = tx_steady ? 0 : idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // one register per cycle; unused upper data bits of the size writes get noise
   task automatic load_regs(input logic [5:0] sx, input logic [5:0] sz,
                            input logic [15:0] ox, input logic [15:0] oz);
      logic [15:0] noise;
      noise = 16'($urandom);
      csr_write <= 1'b1;
      csr_index <= hvfc_pkg::CSR_SIZE_X;
      csr_data  <= {noise[15:6], sx};
      @(posedge clock);
      csr_index <= hvfc_pkg::CSR_SIZE_Z;
      csr_data  <= {noise[9:0], sz};
      @(posedge clock);
      csr_index <= hvfc_pkg::CSR_ORIGIN_X;
      csr_data  <= ox;
      @(posedge clock);
      csr_index <= hvfc_pkg::CSR_ORIGIN_Z;
      csr_data  <= oz;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic run_phase(input logic [5:0] sx, input logic [5:0] sz,
                            input logic [15:0] ox, input logic [15:0] oz,
                            input int n_items, input bit squeeze);
      int esx, esz, bx, bz, r, hv;
      // registers change only once every face is out and the block has settled
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE) @(posedge clock);
      load_regs(sx, sz, ox, oz);
      esx = (sx > hvfc_pkg::MAX_SIDE_DEF) ? hvfc_pkg::MAX_SIDE_DEF : int'(sx);
      esz = (sz > hvfc_pkg::MAX_SIDE_DEF) ? hvfc_pkg::MAX_SIDE_DEF : int'(sz);
      bx  = (esx > 4) ? $urandom_range(0, esx - 4) : 0;
      bz  = (esz > 4) ? $urandom_range(0, esz - 4) : 0;
      if (squeeze) hold_go = 1'b1;
      for (int i = 0; i < n_items; i++) begin
         r  = $urandom_range(0, 99);
         hv = (r < 70) ? $urandom_range(0, 16) :
              (r < 90) ? $urandom_range(0, 64) : $urandom_range(0, 127);
         offer_req(($urandom_range(0, 99) < 45) ? hvfc_pkg::OP_WRITE : hvfc_pkg::OP_QUERY,
                   5'(pick_coord(esx, bx)), 5'(pick_coord(esz, bz)),
                   ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 16)) : 6'($urandom),
                   7'(hv));
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed part with the reset registers (32 x 32, origin 0)
      offer_req(hvfc_pkg::OP_QUERY, 5'd0,  5'd0,  6'd0,  7'd0);    // flat floor corner
      offer_req(hvfc_pkg::OP_QUERY, 5'd0,  5'd0,  6'd1,  7'd0);    // above the column
      offer_req(hvfc_pkg::OP_WRITE, 5'd31, 5'd31, 6'd0,  7'd64);
      offer_req(hvfc_pkg::OP_QUERY, 5'd31, 5'd31, 6'd63, 7'd0);    // top at far corner
      offer_req(hvfc_pkg::OP_QUERY, 5'd31, 5'd31, 6'd0,  7'd0);
      offer_req(hvfc_pkg::OP_WRITE, 5'd5,  5'd5,  6'd63, 7'd127);  // saturates to max
      offer_req(hvfc_pkg::OP_QUERY, 5'd5,  5'd5,  6'd63, 7'd127);
      offer_req(hvfc_pkg::OP_WRITE, 5'd6,  5'd5,  6'd0,  7'd0);
      offer_req(hvfc_pkg::OP_QUERY, 5'd6,  5'd5,  6'd0,  7'd0);    // empty column
      offer_req(hvfc_pkg::OP_WRITE, 5'd9,  5'd10, 6'd0,  7'd20);
      offer_req(hvfc_pkg::OP_WRITE, 5'd11, 5'd10, 6'd0,  7'd20);
      offer_req(hvfc_pkg::OP_WRITE, 5'd10, 5'd9,  6'd0,  7'd20);
      offer_req(hvfc_pkg::OP_WRITE, 5'd10, 5'd11, 6'd0,  7'd20);
      offer_req(hvfc_pkg::OP_WRITE, 5'd10, 5'd10, 6'd0,  7'd20);
      offer_req(hvfc_pkg::OP_QUERY, 5'd10, 5'd10, 6'd5,  7'd0);    // buried voxel, no face
      offer_req(hvfc_pkg::OP_QUERY, 5'd10, 5'd10, 6'd19, 7'd0);    // top face only
      offer_req(hvfc_pkg::OP_QUERY, 5'd10, 5'd10, 6'd0,  7'd0);    // bottom face only
      offer_req(hvfc_pkg::OP_QUERY, 5'd10, 5'd11, 6'd19, 7'd0);
      offer_req(hvfc_pkg::OP_QUERY, 5'd11, 5'd10, 6'd18, 7'd0);    // top layer boundary
      offer_req(hvfc_pkg::OP_QUERY, 5'd31, 5'd0,  6'd0,  7'd0);
      offer_req(hvfc_pkg::OP_QUERY, 5'd0,  5'd31, 6'd0,  7'd0);
      offer_req(hvfc_pkg::OP_WRITE, 5'd0,  5'd0,  6'd63, 7'd1);
      req_valid <= 1'b0;

      run_phase(6'd32, 6'd32, 16'h0000, 16'h0000, 80, 1'b1);
      run_phase(6'd8,  6'd8,  16'($urandom), 16'($urandom), 70, 1'b0);
      run_phase(6'd1,  6'd1,  16'h8000, 16'h7fff, 30, 1'b0);
      run_phase(6'd63, 6'd33, 16'h7fff, 16'h8000, 80, 1'b0);  // sizes beyond capacity
      run_phase(6'd0,  6'd5,  16'($urandom), 16'($urandom), 15, 1'b0);
      run_phase(6'd5,  6'd3,  16'($urandom), 16'($urandom), 60, 1'b0);
      run_phase(6'd12, 6'd20, 16'($urandom), 16'($urandom), 80, 1'b0);
      run_phase(6'd2,  6'd32, 16'hffff, 16'h0001, 45, 1'b0);

      do @(posedge clock); while (pending != 0);
      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

>>> heightmap_voxel_face_culler_core.f
rtl/hvfc_pkg.sv
rtl/hvfc_height_ram.sv
rtl/hvfc_face_seq.sv
rtl/heightmap_voxel_face_culler_core.sv
tb/hvfc_face_checker.sv
tb/tb_heightmap_voxel_face_culler_core.sv
